>>> hdl/grid_cell_layer_allocator_assert.svh
// assertion macros for the grid cell layer allocator
`ifndef GRID_CELL_LAYER_ALLOCATOR_ASSERT_SVH
`define GRID_CELL_LAYER_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define GCLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gcla_pkg.sv
// constants, types and helper functions of the grid cell layer allocator
package gcla_pkg;

  localparam int GRID_COLS  = 32;
  localparam int GRID_ROWS  = 32;
  localparam int CELL_DEPTH = GRID_COLS * GRID_ROWS;

  localparam int COL_W      = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_CNT_W  = COL_W + 1;
  localparam int ROW_CNT_W  = ROW_W + 1;
  localparam int IDX_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int STEP_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int ADDR_W     = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;

  localparam int ACT_W      = 2;
  localparam int POS_W      = 24;
  localparam int RAD_W      = 23;
  localparam int LAYER_W    = 16;
  localparam int CFG_W      = 16;
  localparam int FRAC_W     = 8;
  localparam int SCL_W      = CFG_W + FRAC_W;
  localparam int CRD_W      = POS_W + 2;
  localparam int DIV_W      = SCL_W + IDX_W + 2;
  localparam int EDGE_W     = SCL_W + IDX_W + 4;

  localparam int PADDR_W    = 4;
  localparam int DATA_W     = 32;

  localparam int MIN_CELL_WIDTH = 10;

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] REG_CELL_WIDTH_X = 2'd0;
  localparam logic [1:0] REG_CELL_WIDTH_Z = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X     = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Z     = 2'd3;

  localparam logic [CFG_W-1:0] CELL_WIDTH_RST = 16'd20;
  localparam logic [CFG_W-1:0] ORIGIN_RST     = 16'hFFF6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_DIV,
    ST_EDGE,
    ST_QREAD,
    ST_QWAIT,
    ST_START,
    ST_ROW,
    ST_COL,
    ST_FIN
  } state_e;

  // cell width with the lower limit applied, scaled to the coordinate fraction
  function automatic logic [SCL_W-1:0] scaled_width(input logic [CFG_W-1:0] w);
    logic [CFG_W-1:0] eff;
    eff = (w < CFG_W'(MIN_CELL_WIDTH)) ? CFG_W'(MIN_CELL_WIDTH) : w;
    return {eff, FRAC_W'(0)};
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] i,
                                                  input logic [ROW_W-1:0] j);
    return ADDR_W'(int'(i) * GRID_ROWS + int'(j));
  endfunction

endpackage

>>> hdl/grid_cell_layer_allocator.sv
// grid cell layer allocator: per-cell layer counts kept in one cell memory
//
//   channel   handshake                    payload
//   request   start, busy                  action_i pos_x_i pos_z_i radius_i has_parent_i
//   result    done_o (one-cycle strobe)    layer_o layered_o
//   config    psel penable pwrite pready   paddr pwdata prdata
//
// a layered add finds its start cell with the cell dividers and walks the covered cells
// (R rows of C cells) twice over the cell memory: a read pass, then a write pass
// a query reads one cell, found with the same restoring cell dividers
// a clear, and the clearing pass after reset, sweep all 1024 cells, one per cycle
// busy is high during the clearing pass; results cannot be stalled
module grid_cell_layer_allocator import gcla_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ACT_W-1:0]          action_i,
  input  logic signed [POS_W-1:0]   pos_x_i,
  input  logic signed [POS_W-1:0]   pos_z_i,
  input  logic [RAD_W-1:0]          radius_i,
  input  logic                      has_parent_i,
  output logic [LAYER_W-1:0]        layer_o,
  output logic                      layered_o,
  output logic                      done_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  state_e state_q, state_d;

  logic [CFG_W-1:0]        width_x_q, width_z_q;
  logic signed [CFG_W-1:0] origin_x_q, origin_z_q;

  logic [ACT_W-1:0]        act_q;
  logic signed [CRD_W-1:0] cx_q, x_hi_q, cz_q, z_hi_q;
  logic [DIV_W-1:0]        rem_x_q, rem_z_q, div_x_q, div_z_q;
  logic [IDX_W-1:0]        qx_q, qz_q;
  logic                    sat_x_q, sat_z_q;
  logic [STEP_W-1:0]       step_q;

  logic signed [EDGE_W-1:0] col_base_lo_q, col_base_hi_q, row_base_lo_q, row_base_hi_q;
  logic signed [EDGE_W-1:0] col_lo_q, col_hi_q, row_lo_q, row_hi_q;
  logic [COL_CNT_W-1:0]     t_q;
  logic [ROW_CNT_W-1:0]     j_q;
  logic                     pass_q;
  logic [LAYER_W-1:0]       mx_q;

  logic [ADDR_W-1:0]        sweep_q;
  logic                     clr_item_q;
  logic [LAYER_W-1:0]       res_layer_q;
  logic                     res_layered_q;
  logic [LAYER_W-1:0]       layer_q, layer_d;
  logic                     layered_q, layered_d;
  logic                     done_q, done_d;

  logic [LAYER_W-1:0]       cells [CELL_DEPTH];
  logic [LAYER_W-1:0]       rd_q;
  logic                     rd_vld_q;
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [LAYER_W-1:0]       mem_wdata;

  logic                     acc;
  logic                     cfg_we;
  logic [1:0]               cfg_idx;

  logic [SCL_W-1:0]         wx8, wz8;
  logic signed [SCL_W-1:0]  ox8, oz8;
  logic signed [CRD_W-1:0]  dx, dz;
  logic [DIV_W-1:0]         dx_pos, dz_pos;
  logic                     take_x, take_z;
  logic [IDX_W-1:0]         qx_fin, qz_fin;
  logic [COL_W-1:0]         i0;
  logic [ROW_W-1:0]         j0;
  logic [SCL_W+COL_W-1:0]   col_prod;
  logic [SCL_W+ROW_W-1:0]   row_prod;
  logic signed [EDGE_W-1:0] col_base_lo_d, row_base_lo_d;
  logic signed [EDGE_W-1:0] x_lo_e, x_hi_e, z_lo_e, z_hi_e;
  logic                     tx0, txc, tzr, row_ok, col_ok;
  logic [LAYER_W-1:0]       nv;
  logic [ADDR_W-1:0]        start_addr, cur_addr;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_x_q  <= CELL_WIDTH_RST;
      width_z_q  <= CELL_WIDTH_RST;
      origin_x_q <= ORIGIN_RST;
      origin_z_q <= ORIGIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CELL_WIDTH_X: width_x_q  <= pwdata[CFG_W-1:0];
        REG_CELL_WIDTH_Z: width_z_q  <= pwdata[CFG_W-1:0];
        REG_ORIGIN_X:     origin_x_q <= pwdata[CFG_W-1:0];
        REG_ORIGIN_Z:     origin_z_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CELL_WIDTH_X: prdata = DATA_W'(width_x_q);
      REG_CELL_WIDTH_Z: prdata = DATA_W'(width_z_q);
      REG_ORIGIN_X:     prdata = DATA_W'(origin_x_q);
      REG_ORIGIN_Z:     prdata = DATA_W'(origin_z_q);
      default:          prdata = '0;
    endcase
  end

  // geometry
  assign wx8 = scaled_width(width_x_q);
  assign wz8 = scaled_width(width_z_q);
  assign ox8 = {origin_x_q, FRAC_W'(0)};
  assign oz8 = {origin_z_q, FRAC_W'(0)};

  assign dx     = cx_q - CRD_W'(ox8);
  assign dz     = cz_q - CRD_W'(oz8);
  assign dx_pos = (dx > 0) ? DIV_W'(dx) : '0;
  assign dz_pos = (dz > 0) ? DIV_W'(dz) : '0;
  assign take_x = rem_x_q >= div_x_q;
  assign take_z = rem_z_q >= div_z_q;

  assign qx_fin = sat_x_q ? '1 : qx_q;
  assign qz_fin = sat_z_q ? '1 : qz_q;
  assign i0 = (qx_fin > IDX_W'(GRID_COLS - 1)) ? COL_W'(GRID_COLS - 1) : COL_W'(qx_fin);
  assign j0 = (qz_fin > IDX_W'(GRID_ROWS - 1)) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(qz_fin);

  assign col_prod      = wx8 * i0;
  assign row_prod      = wz8 * j0;
  assign col_base_lo_d = EDGE_W'(ox8) + EDGE_W'(col_prod);
  assign row_base_lo_d = EDGE_W'(oz8) + EDGE_W'(row_prod);

  assign x_lo_e = EDGE_W'(cx_q);
  assign x_hi_e = EDGE_W'(x_hi_q);
  assign z_lo_e = EDGE_W'(cz_q);
  assign z_hi_e = EDGE_W'(z_hi_q);

  assign tx0    = !(col_base_hi_q < x_lo_e) && !(col_base_lo_q > x_hi_e);
  assign txc    = !(col_hi_q < x_lo_e) && !(col_lo_q > x_hi_e);
  assign tzr    = !(row_hi_q < z_lo_e) && !(row_lo_q > z_hi_e);
  assign row_ok = (j_q < ROW_CNT_W'(GRID_ROWS)) && tx0 && tzr;
  assign col_ok = (t_q < COL_CNT_W'(GRID_COLS)) && txc;

  assign nv         = (mx_q == '1) ? '1 : mx_q + LAYER_W'(1);
  assign start_addr = cell_addr(i0, j0);
  assign cur_addr   = cell_addr(t_q[COL_W-1:0], j_q[ROW_W-1:0]);

  assign busy = (state_q != ST_IDLE);
  assign acc  = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (action_i)
            ACT_ADD:   state_d = has_parent_i ? ST_INIT : ST_FIN;
            ACT_QUERY: state_d = ST_INIT;
            ACT_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_FIN;
          endcase
        end
      end
      ST_CLEAR: begin
        if (sweep_q == ADDR_W'(CELL_DEPTH - 1)) begin
          state_d = clr_item_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == '0) begin
          state_d = (act_q == ACT_QUERY) ? ST_QREAD : ST_EDGE;
        end
      end
      ST_EDGE:  state_d = ST_START;
      ST_START: state_d = ST_ROW;
      ST_ROW: begin
        if (row_ok) begin
          state_d = ST_COL;
        end else begin
          state_d = pass_q ? ST_FIN : ST_START;
        end
      end
      ST_COL: begin
        if (!col_ok) begin
          state_d = ST_ROW;
        end
      end
      ST_QREAD: state_d = ST_QWAIT;
      ST_QWAIT: state_d = ST_IDLE;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cur_addr;
    mem_raddr = cur_addr;
    mem_wdata = nv;
    done_d    = 1'b0;
    layer_d   = '0;
    layered_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
      end
      ST_QREAD: begin
        mem_re    = 1'b1;
        mem_raddr = start_addr;
      end
      ST_QWAIT: begin
        done_d  = 1'b1;
        layer_d = rd_q;
      end
      ST_START: begin
        mem_we    = pass_q;
        mem_re    = !pass_q;
        mem_waddr = start_addr;
        mem_raddr = start_addr;
      end
      ST_COL: begin
        mem_we = col_ok && pass_q;
        mem_re = col_ok && !pass_q;
      end
      ST_FIN: begin
        done_d    = 1'b1;
        layer_d   = res_layer_q;
        layered_d = res_layered_q;
      end
      default: ;
    endcase
  end

  // cell memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= cells[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      sweep_q    <= '0;
      clr_item_q <= 1'b0;
      pass_q     <= 1'b0;
      rd_vld_q   <= 1'b0;
      done_q     <= 1'b0;
      layered_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= mem_re;
      done_q    <= done_d;
      layered_q <= layered_d;
      if (acc) begin
        sweep_q    <= '0;
        clr_item_q <= (action_i == ACT_CLEAR);
      end else if (state_q == ST_CLEAR) begin
        sweep_q <= sweep_q + ADDR_W'(1);
      end
      if (state_q == ST_EDGE) begin
        pass_q <= 1'b0;
      end else if (state_q == ST_ROW && !row_ok) begin
        pass_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    layer_q <= layer_d;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (rd_q > mx_q)) begin
      mx_q <= rd_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          act_q         <= action_i;
          cx_q          <= (action_i == ACT_ADD) ?
                           CRD_W'(pos_x_i) - CRD_W'(radius_i) : CRD_W'(pos_x_i);
          cz_q          <= (action_i == ACT_ADD) ?
                           CRD_W'(pos_z_i) - CRD_W'(radius_i) : CRD_W'(pos_z_i);
          x_hi_q        <= CRD_W'(pos_x_i) + CRD_W'(radius_i);
          z_hi_q        <= CRD_W'(pos_z_i) + CRD_W'(radius_i);
          res_layer_q   <= '0;
          res_layered_q <= 1'b0;
        end
      end
      ST_INIT: begin
        rem_x_q <= dx_pos;
        rem_z_q <= dz_pos;
        div_x_q <= DIV_W'(wx8) << (IDX_W - 1);
        div_z_q <= DIV_W'(wz8) << (IDX_W - 1);
        sat_x_q <= dx_pos >= (DIV_W'(wx8) << IDX_W);
        sat_z_q <= dz_pos >= (DIV_W'(wz8) << IDX_W);
        qx_q    <= '0;
        qz_q    <= '0;
        step_q  <= STEP_W'(IDX_W - 1);
      end
      ST_DIV: begin
        if (take_x) begin
          rem_x_q      <= rem_x_q - div_x_q;
          qx_q[step_q] <= 1'b1;
        end
        if (take_z) begin
          rem_z_q      <= rem_z_q - div_z_q;
          qz_q[step_q] <= 1'b1;
        end
        div_x_q <= div_x_q >> 1;
        div_z_q <= div_z_q >> 1;
        step_q  <= step_q - STEP_W'(1);
      end
      ST_EDGE: begin
        col_base_lo_q <= col_base_lo_d;
        col_base_hi_q <= col_base_lo_d + EDGE_W'(wx8);
        row_base_lo_q <= row_base_lo_d;
        row_base_hi_q <= row_base_lo_d + EDGE_W'(wz8);
        mx_q          <= '0;
      end
      ST_START: begin
        j_q      <= ROW_CNT_W'(j0);
        row_lo_q <= row_base_lo_q;
        row_hi_q <= row_base_hi_q;
      end
      ST_ROW: begin
        if (row_ok) begin
          t_q      <= COL_CNT_W'(i0);
          col_lo_q <= col_base_lo_q;
          col_hi_q <= col_base_hi_q;
        end else if (pass_q) begin
          res_layer_q   <= mx_q;
          res_layered_q <= 1'b1;
        end
      end
      ST_COL: begin
        if (col_ok) begin
          t_q      <= t_q + COL_CNT_W'(1);
          col_lo_q <= col_lo_q + EDGE_W'(wx8);
          col_hi_q <= col_hi_q + EDGE_W'(wx8);
        end else begin
          j_q      <= j_q + ROW_CNT_W'(1);
          row_lo_q <= row_lo_q + EDGE_W'(wz8);
          row_hi_q <= row_hi_q + EDGE_W'(wz8);
        end
      end
      default: ;
    endcase
  end

  assign done_o    = done_q;
  assign layer_o   = layer_q;
  assign layered_o = layered_q;

endmodule

>>> hdl/gcla_checker.sv
// port-level checker for the grid cell layer allocator and its bind
`include "grid_cell_layer_allocator_assert.svh"

module gcla_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic done_i,
  input logic layered_i
);

  `GCLA_ASSERT_NXT(a_accept_busy, start_i && !busy_i, busy_i, "accepted request left busy low")
  `GCLA_ASSERT_IMP(a_done_idle, done_i, !busy_i, "result shown while still busy")
  `GCLA_ASSERT_NXT(a_done_single, done_i, !done_i, "result strobe held for two cycles")
  `GCLA_ASSERT_IMP(a_layered_done, layered_i, done_i, "layered flag without result strobe")

endmodule

bind grid_cell_layer_allocator gcla_checker u_gcla_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start),
  .busy_i    (busy),
  .done_i    (done_o),
  .layered_i (layered_o)
);

>>> bench/grid_cell_layer_allocator_tb.sv
// self-checking testbench for the grid cell layer allocator: directed table, random requests
module grid_cell_layer_allocator_tb import gcla_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time CLK_PERIOD    = 12ns;
  localparam int  STALL_LIMIT   = 20000;
  localparam int  DRAIN_CYCLES  = 2500;
  localparam int  PHASE_ITEMS   = 215;
  localparam int  QUIET_FIRST   = 500;
  localparam int  QUIET_LAST    = 800;
  localparam int  MAX_REPORTS   = 10;
  localparam longint POS_MAX    = 64'sd8388607;
  localparam longint POS_MIN    = -64'sd8388608;
  localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic               layered;
  } layer_result_t;

  typedef struct {
    logic [ACT_W-1:0]   act;
    int                 x;
    int                 z;
    int                 r;
    bit                 parent;
    bit                 typed;
    logic [LAYER_W-1:0] layer;
    bit                 layered;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [ACT_W-1:0]        action_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_z_i;
  logic [RAD_W-1:0]        radius_i;
  logic                    has_parent_i;
  logic [LAYER_W-1:0]      layer_o;
  logic                    layered_o;
  logic                    done_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  logic                    typed_on;
  logic [LAYER_W-1:0]      typed_layer;
  logic                    typed_layered;

  logic [CFG_W-1:0]        cfg_width_x  = CELL_WIDTH_RST;
  logic [CFG_W-1:0]        cfg_width_z  = CELL_WIDTH_RST;
  logic signed [CFG_W-1:0] cfg_origin_x = ORIGIN_RST;
  logic signed [CFG_W-1:0] cfg_origin_z = ORIGIN_RST;
  logic [LAYER_W-1:0]      cell_counts [CELL_DEPTH];

  layer_result_t           layer_answers_q [$];
  stim_row_t               directed_rows [$];
  int                      mismatch_count = 0;
  int                      stall_cycles = 0;
  int                      issued_count = 0;

  grid_cell_layer_allocator dut (
    .clk_i, .rst_ni, .start, .busy,
    .action_i, .pos_x_i, .pos_z_i, .radius_i, .has_parent_i,
    .layer_o, .layered_o, .done_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint eff_width(logic [CFG_W-1:0] w);
    return (w < CFG_W'(MIN_CELL_WIDTH)) ? longint'(MIN_CELL_WIDTH) : longint'(w);
  endfunction

  function automatic longint cell_of(longint coord, longint org, longint w, longint cells);
    longint d;
    longint c;
    d = coord - org * 256;
    if (d <= 0) return 0;
    c = d / (w * 256);
    return (c > cells - 1) ? cells - 1 : c;
  endfunction

  function automatic bit covers(longint i, longint j, longint x, longint z, longint r);
    longint wx;
    longint wz;
    longint ox;
    longint oz;
    wx = eff_width(cfg_width_x) * 256;
    wz = eff_width(cfg_width_z) * 256;
    ox = longint'(cfg_origin_x) * 256;
    oz = longint'(cfg_origin_z) * 256;
    if (ox + wx * (i + 1) < x - r) return 1'b0;
    if (ox + wx * i > x + r) return 1'b0;
    if (oz + wz * (j + 1) < z - r) return 1'b0;
    if (oz + wz * j > z + r) return 1'b0;
    return 1'b1;
  endfunction

  function automatic layer_result_t apply_request(logic [ACT_W-1:0] act, longint x, longint z,
                                                  longint r, bit par);
    layer_result_t      res;
    longint             i0;
    longint             j0;
    longint             j;
    longint             t;
    logic [LAYER_W-1:0] peak;
    logic [LAYER_W-1:0] bumped;
    res = '0;
    if (act == ACT_ADD && par) begin
      i0 = cell_of(x - r, longint'(cfg_origin_x), eff_width(cfg_width_x), GRID_COLS);
      j0 = cell_of(z - r, longint'(cfg_origin_z), eff_width(cfg_width_z), GRID_ROWS);
      peak = cell_counts[int'(i0 * GRID_ROWS + j0)];
      bumped = '0;
      // first walk finds the peak count, second walk stamps peak + 1
      for (int pass = 0; pass < 2; pass++) begin
        if (pass == 1) begin
          bumped = (peak == '1) ? peak : peak + 1'b1;
          cell_counts[int'(i0 * GRID_ROWS + j0)] = bumped;
        end
        j = j0;
        while (j < GRID_ROWS && covers(i0, j, x, z, r)) begin
          t = i0;
          while (t < GRID_COLS && covers(t, j, x, z, r)) begin
            if (pass == 0) begin
              if (cell_counts[int'(t * GRID_ROWS + j)] > peak)
                peak = cell_counts[int'(t * GRID_ROWS + j)];
            end else begin
              cell_counts[int'(t * GRID_ROWS + j)] = bumped;
            end
            t++;
          end
          j++;
        end
      end
      res.layer = peak;
      res.layered = 1'b1;
    end else if (act == ACT_QUERY) begin
      i0 = cell_of(x, longint'(cfg_origin_x), eff_width(cfg_width_x), GRID_COLS);
      j0 = cell_of(z, longint'(cfg_origin_z), eff_width(cfg_width_z), GRID_ROWS);
      res.layer = cell_counts[int'(i0 * GRID_ROWS + j0)];
    end else if (act == ACT_CLEAR) begin
      foreach (cell_counts[k]) cell_counts[k] = '0;
    end
    return res;
  endfunction

  function automatic void flag_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  function automatic void add_row(logic [ACT_W-1:0] act, int x, int z, int r, bit parent,
                                  bit typed, logic [LAYER_W-1:0] layer, bit layered);
    stim_row_t row;
    row = '{act, x, z, r, parent, typed, layer, layered};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  always @(posedge clk_i) begin : check_results
    layer_result_t want;
    if (rst_ni && start && !busy) begin
      want = apply_request(action_i, longint'(pos_x_i), longint'(pos_z_i),
                           longint'(radius_i), has_parent_i);
      if (typed_on) begin
        want.layer = typed_layer;
        want.layered = typed_layered;
      end
      layer_answers_q.insert(layer_answers_q.size(), want);
    end
    if (rst_ni && done_o) begin
      if (layer_answers_q.size() == 0) begin
        flag_mismatch("unrequested result layer", -1, longint'(layer_o));
      end else begin
        want = layer_answers_q.pop_front();
        if (layer_o !== want.layer) flag_mismatch("layer", want.layer, layer_o);
        if (layered_o !== want.layered) flag_mismatch("layered", want.layered, layered_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [POS_W-1:0] clip_pos(longint v);
    if (v > POS_MAX) return POS_W'(POS_MAX);
    if (v < POS_MIN) return POS_W'(POS_MIN);
    return POS_W'(v);
  endfunction

  function automatic logic [POS_W-1:0] place(longint org, longint w, int cells, int hot);
    longint col;
    longint v;
    if ($urandom_range(0, 9) < 7) col = hot + $urandom_range(0, 7);
    else col = longint'($urandom_range(0, cells + 3)) - 2;
    v = (org + w * col) * 256;
    if ($urandom_range(0, 7) != 0) v += $urandom_range(0, 32'(w * 256 - 1));
    return clip_pos(v);
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius(longint w);
    int     k;
    longint v;
    k = $urandom_range(0, 19);
    if (k == 0) v = $urandom_range(0, 32'(POS_MAX));
    else if (k < 8) v = $urandom_range(0, 255);
    else v = $urandom_range(0, 32'((k % 3 + 1) * w * 256));
    return (v > POS_MAX) ? RAD_W'(POS_MAX) : RAD_W'(v);
  endfunction

  task automatic issue(logic [ACT_W-1:0] act, logic [POS_W-1:0] x, logic [POS_W-1:0] z,
                       logic [RAD_W-1:0] r, bit par, bit typed = 1'b0,
                       logic [LAYER_W-1:0] lay = '0, bit ld = 1'b0);
    @(negedge clk_i);
    action_i = act;
    pos_x_i = x;
    pos_z_i = z;
    radius_i = r;
    has_parent_i = par;
    typed_on = typed;
    typed_layer = lay;
    typed_layered = ld;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    issued_count++;
  endtask

  task automatic idle_gap();
    if (issued_count >= QUIET_FIRST && issued_count < QUIET_LAST) return;
    if ($urandom_range(0, 99) < 24) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (layer_answers_q.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_register(logic [1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = PADDR_W'({idx, 2'b00});
    pwdata = DATA_W'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_CELL_WIDTH_X: cfg_width_x = value;
      REG_CELL_WIDTH_Z: cfg_width_z = value;
      REG_ORIGIN_X:     cfg_origin_x = value;
      REG_ORIGIN_Z:     cfg_origin_z = value;
      default: ;
    endcase
    @(negedge clk_i);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== value) flag_mismatch("register readback", value, prdata[CFG_W-1:0]);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_grid(logic [CFG_W-1:0] wx, logic [CFG_W-1:0] wz,
                          logic [CFG_W-1:0] ox, logic [CFG_W-1:0] oz);
    settle();
    program_register(REG_CELL_WIDTH_X, wx);
    program_register(REG_CELL_WIDTH_Z, wz);
    program_register(REG_ORIGIN_X, ox);
    program_register(REG_ORIGIN_Z, oz);
  endtask

  task automatic random_phase(int quota);
    int                 counted;
    int                 pick;
    int                 hot_i;
    int                 hot_j;
    logic [ACT_W-1:0]   act;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   z;
    logic [RAD_W-1:0]   r;
    bit                 par;
    counted = 0;
    hot_i = $urandom_range(0, GRID_COLS > 8 ? GRID_COLS - 8 : 0);
    hot_j = $urandom_range(0, GRID_ROWS > 8 ? GRID_ROWS - 8 : 0);
    while (counted < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        act = ACT_W'($urandom);
        x = POS_W'($urandom);
        z = POS_W'($urandom);
        r = RAD_W'($urandom);
        par = 1'($urandom);
      end else begin
        if (pick < 60) act = ACT_ADD;
        else if (pick < 95) act = ACT_QUERY;
        else if (pick < 97) act = ACT_CLEAR;
        else act = ACT_IGNORED;
        x = place(longint'(cfg_origin_x), eff_width(cfg_width_x), GRID_COLS, hot_i);
        z = place(longint'(cfg_origin_z), eff_width(cfg_width_z), GRID_ROWS, hot_j);
        r = pick_radius(eff_width(cfg_width_x));
        par = ($urandom_range(0, 9) != 0);
      end
      issue(act, x, z, r, par);
      if (act != ACT_IGNORED) counted++;
      idle_gap();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    action_i = ACT_ADD;
    pos_x_i = '0;
    pos_z_i = '0;
    radius_i = '0;
    has_parent_i = 1'b0;
    typed_on = 1'b0;
    typed_layer = '0;
    typed_layered = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (cell_counts[k]) cell_counts[k] = '0;

    // x, z, r with 8 fraction bits; reset grid is 20 units wide from -10
    add_row(ACT_QUERY,   0, 0, 0, 1'b0, 1'b1, 16'd0, 1'b0);
    add_row(ACT_ADD,     0, 0, 0, 1'b0, 1'b1, 16'd0, 1'b0);
    add_row(ACT_IGNORED, 0, 0, 0, 1'b1, 1'b1, 16'd0, 1'b0);
    add_row(ACT_ADD,     0, 0, 0, 1'b1, 1'b1, 16'd0, 1'b1);
    add_row(ACT_ADD,     0, 0, 0, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(ACT_QUERY,   0, 0, 0, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(ACT_ADD, -8388608, -8388608, 0, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(ACT_ADD,  8388607,  8388607, 0, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(ACT_QUERY, 8388607,  8388607, 0, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(ACT_QUERY, -8388608, 8388607, 0, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(ACT_ADD, -2560, -2560, 0, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(ACT_ADD,  2560,  7680, 0, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(ACT_QUERY, 2560, 2560, 0, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(ACT_QUERY, 2559, 2559, 0, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(ACT_ADD, 76800, 76800, 6400, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(ACT_ADD, 0, 0, 8388607, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(ACT_QUERY, 81920, 81920, 0, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(ACT_ADD, 0, 0, 8388607, 1'b0, 1'b1, 16'd0, 1'b0);
    add_row(ACT_ADD, 0, 0, 8388607, 1'b1, 1'b0, 16'd0, 1'b0);
    add_row(ACT_CLEAR, 0, 0, 0, 1'b0, 1'b1, 16'd0, 1'b0);
    add_row(ACT_QUERY, 76800, 76800, 0, 1'b0, 1'b1, 16'd0, 1'b0);
    add_row(ACT_ADD, 76800, 0, 10240, 1'b1, 1'b1, 16'd0, 1'b1);
    add_row(ACT_IGNORED, -1, -1, 8388607, 1'b1, 1'b1, 16'd0, 1'b0);
    add_row(ACT_QUERY, -1, -1, 0, 1'b0, 1'b0, 16'd0, 1'b0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[n]) begin
      issue(directed_rows[n].act, POS_W'(directed_rows[n].x), POS_W'(directed_rows[n].z),
            RAD_W'(directed_rows[n].r), directed_rows[n].parent, directed_rows[n].typed,
            directed_rows[n].layer, directed_rows[n].layered);
      idle_gap();
    end
    random_phase(PHASE_ITEMS);

    set_grid(16'd0, 16'hFFFF, 16'h8000, 16'h7FFF);
    random_phase(PHASE_ITEMS);
    set_grid(16'hFFFF, 16'd5, 16'h7FFF, 16'h8000);
    random_phase(PHASE_ITEMS);
    set_grid(16'd10, 16'd10, 16'h0000, 16'h0000);
    random_phase(PHASE_ITEMS);
    set_grid(16'd37, 16'd23, -16'sd200, 16'sd150);
    random_phase(PHASE_ITEMS);
    set_grid(CFG_W'($urandom_range(10, 300)), CFG_W'($urandom_range(10, 300)),
             CFG_W'(int'($urandom_range(0, 1000)) - 500),
             CFG_W'(int'($urandom_range(0, 1000)) - 500));
    random_phase(PHASE_ITEMS);

    @(negedge clk_i);
    start = 1'b0;
    while (layer_answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (layer_answers_q.size() != 0)
      flag_mismatch("missing results", 0, layer_answers_q.size());
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
